// File: sv/shs_pkg.sv
package shs_pkg;

    localparam int DATA_W    = 64;
    localparam int WORD_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 6;
    localparam int POS_W     = 3;
    localparam int LANES     = 8;
    localparam int CFG_IDX_W = 2;

    // register indexes on the config channel
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_CONST = 2'd1;

    localparam logic [BYTE_W-1:0] CHAR_MASK  = 8'h05;
    localparam logic [BYTE_W-1:0] LEN_MARK   = 8'h80;
    localparam logic [BYTE_W-1:0] BLOCK_LEN  = 8'd8;
    localparam int                ROT_R      = 8;
    localparam int                ROT_L      = 3;

    // one unit of work handed from the front to the back
    typedef struct packed {
        logic                  fin;   // string end: finalize and emit
        logic [POS_W-1:0]      rem;   // bytes in the trailing partial block
        logic [DATA_W-1:0]     data;  // packed block
    } job_t;

    // control between back sequencer and cipher
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] block;
    } cipher_req_t;

    // value enciphered at string end: accumulator with length tag folded in
    function automatic logic [DATA_W-1:0] final_word(input logic [DATA_W-1:0] acc,
                                                     input logic [POS_W-1:0]  rem);
        logic [BYTE_W-1:0] len_byte;
        logic [DATA_W-1:0] h;
        len_byte = (rem != '0) ? (BYTE_W'(rem) - BLOCK_LEN) : '0;
        h = acc ^ DATA_W'(len_byte);
        if (rem[0]) begin
            h[WORD_W +: BYTE_W] = h[WORD_W +: BYTE_W] ^ LEN_MARK;
        end else begin
            h[0 +: BYTE_W] = h[0 +: BYTE_W] ^ LEN_MARK;
        end
        return h;
    endfunction

endpackage

// File: sv/shs_front.sv
module shs_front #(
    parameter int MAX_STRING_BYTES = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     beat_in,
    input  logic [shs_pkg::BYTE_W-1:0] char_byte,
    output logic                     push,
    output shs_pkg::job_t            push_job
);

    logic [shs_pkg::DATA_W-1:0] buf_reg, buf_next;
    logic [shs_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [shs_pkg::DATA_W-1:0] packed_word;
    logic [shs_pkg::CNT_W-1:0]  cnt_inc;
    logic [shs_pkg::BYTE_W-1:0] masked;

    assign masked  = char_byte ^ shs_pkg::CHAR_MASK;
    assign cnt_inc = cnt_reg + 1'b1;

    always_comb begin
        packed_word = buf_reg;
        for (int i = 0; i < shs_pkg::LANES; i++) begin
            if (cnt_reg[shs_pkg::POS_W-1:0] == shs_pkg::POS_W'(i)) begin
                packed_word[i*shs_pkg::BYTE_W +: shs_pkg::BYTE_W] = masked;
            end
        end
    end

    always_comb begin
        buf_next      = buf_reg;
        cnt_next      = cnt_reg;
        push          = 1'b0;
        push_job.fin  = 1'b0;
        push_job.rem  = cnt_reg[shs_pkg::POS_W-1:0];
        push_job.data = buf_reg;
        if (beat_in) begin
            if (char_byte == '0) begin
                push         = 1'b1;
                push_job.fin = 1'b1;
                buf_next     = '0;
                cnt_next     = '0;
            end else if (cnt_reg < shs_pkg::CNT_W'(MAX_STRING_BYTES)) begin
                cnt_next = cnt_inc;
                if (cnt_inc[shs_pkg::POS_W-1:0] == '0) begin
                    push          = 1'b1;
                    push_job.data = packed_word;
                    buf_next      = '0;
                end else begin
                    buf_next = packed_word;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg <= '0;
            cnt_reg <= '0;
        end else begin
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: sv/shs_queue.sv
module shs_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  shs_pkg::job_t push_job,
    input  logic          pop,
    output shs_pkg::job_t head,
    output logic          not_empty,
    output logic          full
);

    localparam int DEPTH = 2;

    shs_pkg::job_t slot_reg [DEPTH];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'(DEPTH));

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: sv/shs_cipher.sv
module shs_cipher #(
    parameter int ROUNDS = 27
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  shs_pkg::cipher_req_t       req,
    input  logic [shs_pkg::DATA_W-1:0] key_low,
    input  logic [shs_pkg::DATA_W-1:0] init_constant,
    output logic                       busy,
    output logic [shs_pkg::DATA_W-1:0] result
);

    localparam int RND_W = $clog2(ROUNDS + 1);
    localparam int W     = shs_pkg::WORD_W;

    logic [W-1:0] x0_reg, x1_reg, k0_reg, k1_reg, k2_reg, k3_reg;
    logic [W-1:0] x0_next, x1_next, k0_next, nk1;
    logic [RND_W-1:0] rnd_reg;
    logic             busy_reg;
    logic [shs_pkg::DATA_W-1:0] hi_key;

    assign hi_key = key_low ^ init_constant;

    // one Speck round on data and key schedule side by side
    always_comb begin
        x0_next = ({x0_reg[shs_pkg::ROT_R-1:0], x0_reg[W-1:shs_pkg::ROT_R]} + x1_reg)
                  ^ k0_reg;
        x1_next = {x1_reg[W-shs_pkg::ROT_L-1:0], x1_reg[W-1:W-shs_pkg::ROT_L]} ^ x0_next;
        nk1     = ({k1_reg[shs_pkg::ROT_R-1:0], k1_reg[W-1:shs_pkg::ROT_R]} + k0_reg)
                  ^ W'(rnd_reg);
        k0_next = {k0_reg[W-shs_pkg::ROT_L-1:0], k0_reg[W-1:W-shs_pkg::ROT_L]} ^ nk1;
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            x0_reg <= req.block[W-1:0];
            x1_reg <= req.block[2*W-1:W];
            k0_reg <= key_low[W-1:0];
            k1_reg <= key_low[2*W-1:W];
            k2_reg <= hi_key[W-1:0];
            k3_reg <= hi_key[2*W-1:W];
        end else if (busy_reg) begin
            x0_reg <= x0_next;
            x1_reg <= x1_next;
            k0_reg <= k0_next;
            k1_reg <= k2_reg;
            k2_reg <= k3_reg;
            k3_reg <= nk1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rnd_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            rnd_reg  <= '0;
        end else if (busy_reg) begin
            rnd_reg <= rnd_reg + 1'b1;
            if (rnd_reg == RND_W'(ROUNDS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy   = busy_reg;
    assign result = {x1_reg, x0_reg};

endmodule

// File: sv/shs_back.sv
module shs_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  shs_pkg::job_t              head,
    input  logic                       not_empty,
    output logic                       pop,
    output shs_pkg::cipher_req_t       req,
    input  logic                       cipher_busy,
    input  logic [shs_pkg::DATA_W-1:0] cipher_result,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [shs_pkg::DATA_W-1:0] m_tdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BLK  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                 st_reg, st_next;
    logic                       fin_reg, fin_next;
    logic [shs_pkg::POS_W-1:0]  rem_reg, rem_next;
    logic [shs_pkg::DATA_W-1:0] acc_reg, acc_next, acc_blk;
    logic                       ov_reg, ov_next;
    logic [shs_pkg::DATA_W-1:0] od_reg, od_next;
    logic                       out_free;

    assign out_free = !ov_reg || m_tready;
    assign acc_blk  = acc_reg ^ cipher_result;

    always_comb begin
        st_next   = st_reg;
        fin_next  = fin_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        ov_next   = (ov_reg && m_tready) ? 1'b0 : ov_reg;
        od_next   = od_reg;
        pop       = 1'b0;
        req.start = 1'b0;
        req.block = head.data;
        unique case (st_reg)
            ST_IDLE: begin
                if (not_empty) begin
                    pop       = 1'b1;
                    req.start = 1'b1;
                    fin_next  = head.fin;
                    rem_next  = head.rem;
                    if (head.fin && head.rem == '0) begin
                        req.block = shs_pkg::final_word(acc_reg, head.rem);
                        st_next   = ST_FIN;
                    end else begin
                        st_next = ST_BLK;
                    end
                end
            end
            ST_BLK: begin
                if (!cipher_busy) begin
                    acc_next = acc_blk;
                    if (fin_reg) begin
                        req.start = 1'b1;
                        req.block = shs_pkg::final_word(acc_blk, rem_reg);
                        st_next   = ST_FIN;
                    end else begin
                        st_next = ST_IDLE;
                    end
                end
            end
            ST_FIN: begin
                if (!cipher_busy && out_free) begin
                    ov_next  = 1'b1;
                    od_next  = cipher_result;
                    acc_next = '0;
                    st_next  = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_IDLE;
            acc_reg <= '0;
            ov_reg  <= 1'b0;
        end else begin
            st_reg  <= st_next;
            acc_reg <= acc_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        fin_reg <= fin_next;
        rem_reg <= rem_next;
        od_reg  <= od_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !cipher_busy)
        else $error("cipher restarted mid-run");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_FIN && !cipher_busy && out_free) |=> (acc_reg == '0 && ov_reg))
        else $error("hash emit did not clear accumulator");

    a_busy_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_IDLE && not_empty) |=> cipher_busy)
        else $error("dispatched job did not start cipher");

endmodule

// File: sv/speck_string_hash.sv
// Channel  | Ports                                   | Beat carries
// ---------+-----------------------------------------+-------------------------------
// in       | s_tvalid s_tready s_tdata[7:0]          | [7:0] char_byte
// out      | m_tvalid m_tready m_tdata[63:0]         | [63:0] hash_value
// config   | cfg_valid cfg_ready cfg_index cfg_data  | idx 0 key_low, idx 1 init_constant
//
// The front packs each accepted byte; every 8th counted byte (and the
// terminating zero) queues a job. The back runs one cipher round per cycle,
// one block at a time. A terminating zero needs an encipherment of the
// final word, after the zero-padded tail block if one is open, before the
// hash beat; block jobs still queued ahead of it in the back go first.
// s_tready drops only while the two-entry job queue is full; a stalled m_tready
// holds the back in its final state. aresetn is synchronous; no clearing pass.
module speck_string_hash #(
    parameter int MAX_STRING_BYTES = 32,
    parameter int ROUNDS           = 27
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,    // [7:0] char_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,    // [63:0] hash_value
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [shs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);

    logic [shs_pkg::DATA_W-1:0] key_low_reg, init_const_reg;
    logic                       beat_in;
    logic                       push, pop, q_not_empty, q_full;
    shs_pkg::job_t              push_job, head;
    shs_pkg::cipher_req_t       req;
    logic                       cipher_busy;
    logic [shs_pkg::DATA_W-1:0] cipher_result;

    // config always taken; host must write only while no beat is in flight; not enforced
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg    <= '0;
            init_const_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == shs_pkg::REG_KEY_LOW) begin
                key_low_reg <= cfg_data;
            end else if (cfg_index == shs_pkg::REG_INIT_CONST) begin
                init_const_reg <= cfg_data;
            end
        end
    end

    // each byte can queue at most one job, so a free slot is enough
    assign s_tready = !q_full;
    assign beat_in  = s_tvalid && s_tready;

    shs_front #(
        .MAX_STRING_BYTES(MAX_STRING_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat_in   (beat_in),
        .char_byte (s_tdata),
        .push      (push),
        .push_job  (push_job)
    );

    shs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .head      (head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    shs_cipher #(
        .ROUNDS(ROUNDS)
    ) u_cipher (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req           (req),
        .key_low       (key_low_reg),
        .init_constant (init_const_reg),
        .busy          (cipher_busy),
        .result        (cipher_result)
    );

    shs_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .not_empty     (q_not_empty),
        .pop           (pop),
        .req           (req),
        .cipher_busy   (cipher_busy),
        .cipher_result (cipher_result),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule

// File: test/tb_speck_string_hash.sv
`timescale 1ns / 100ps

module tb_speck_string_hash;

    // Block defaults, mirrored locally for the predictor.
    localparam int STR_LIMIT  = 32;   // bytes of a string that count
    localparam int CIPHER_RND = 27;   // Speck rounds per block

    localparam logic [7:0] CHAR_XOR = 8'h05;   // applied to every packed byte
    localparam logic [7:0] LEN_TAG  = 8'h80;   // length marker bit

    // Indexes past the two real registers; writes there must change nothing.
    localparam logic [shs_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [shs_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // Idle gap before any key change or the end of run.
    localparam int SETTLE_CYCLES = 100;
    // Long output hold used to back the job queue up into the input.
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASE_BYTES   = 170;

    // ---------------------------------------------------------------
    // Clock, reset, DUT pins. Everything starts at a known value.
    // ---------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;   // [7:0] char_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;             // [63:0] hash_value
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [shs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]                   cfg_data  = '0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    speck_string_hash dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------
    // Predictor: own copy of the key registers and per-string state.
    // ---------------------------------------------------------------
    logic [63:0] key_lo  = '0;   // register 0
    logic [63:0] key_mix = '0;   // register 1, upper key = key_lo ^ key_mix
    logic [63:0] str_block = '0; // packed bytes of the open block
    logic [5:0]  str_bytes = '0; // counted bytes, saturates at STR_LIMIT
    logic [63:0] str_acc   = '0; // XOR of enciphered blocks

    logic [63:0] pending_hashes [$];

    int err_count      = 0;
    int hashes_checked = 0;
    int bytes_sent     = 0;
    int strings_sent   = 0;
    int long_strings   = 0;
    int key_settings   = 1;
    int in_stall_cycles = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got %016h want %016h", $time, what, got, want);
        err_count++;
    endtask

    // Speck64/128: x0 = low word, x1 = high word; key words k0,k1 from the
    // low key half, k2,k3 from the upper half.
    function automatic logic [63:0] speck_enc(input logic [63:0] blk,
                                              input logic [63:0] klo,
                                              input logic [63:0] kmix);
        logic [63:0] khi;
        logic [31:0] k0, k1, k2, k3, x0, x1, nk;
        int r;
        khi = klo ^ kmix;
        k0 = klo[31:0];
        k1 = klo[63:32];
        k2 = khi[31:0];
        k3 = khi[63:32];
        x0 = blk[31:0];
        x1 = blk[63:32];
        for (r = 0; r < CIPHER_RND; r++) begin
            x0 = ({x0[7:0], x0[31:8]} + x1) ^ k0;
            x1 = {x1[28:0], x1[31:29]} ^ x0;
            nk = ({k1[7:0], k1[31:8]} + k0) ^ 32'(r);
            k0 = {k0[28:0], k0[31:29]} ^ nk;
            k1 = k2;
            k2 = k3;
            k3 = nk;
        end
        return {x1, x0};
    endfunction

    // One accepted byte; a zero byte closes the string and queues its hash.
    task automatic absorb_char(input logic [7:0] c);
        logic [2:0]  rem;
        logic [7:0]  len_byte;
        logic [63:0] h;
        if (c != 8'h00) begin
            // past the limit the byte is dropped
            if (str_bytes < STR_LIMIT) begin
                str_block[str_bytes[2:0]*8 +: 8] = c ^ CHAR_XOR;
                str_bytes = str_bytes + 6'd1;
                if (str_bytes[2:0] == 3'd0) begin
                    str_acc   = str_acc ^ speck_enc(str_block, key_lo, key_mix);
                    str_block = '0;
                end
            end
        end else begin
            rem      = str_bytes[2:0];
            len_byte = 8'h00;
            if (rem != 3'd0) begin
                // zero-padded tail block; len = rem - 8, taken mod 256
                str_acc  = str_acc ^ speck_enc(str_block, key_lo, key_mix);
                len_byte = {5'b0, rem} - 8'd8;
            end
            // empty string and whole blocks: marker lands in word 0
            h = str_acc ^ {56'b0, len_byte};
            h[rem[0]*32 +: 8] = h[rem[0]*32 +: 8] ^ LEN_TAG;
            pending_hashes.push_back(speck_enc(h, key_lo, key_mix));
            str_block = '0;
            str_bytes = '0;
            str_acc   = '0;
        end
    endtask

    // ---------------------------------------------------------------
    // Output side: ready pattern driven at the falling edge, beats checked
    // at the rising edge against the oldest predicted hash.
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !s_tready)
                in_stall_cycles++;
            if (m_tvalid && m_tready) begin
                if (pending_hashes.size() == 0) begin
                    report_mismatch("unexpected hash beat", m_tdata, 64'h0);
                end else begin
                    if (m_tdata !== pending_hashes[0])
                        report_mismatch("hash_value", m_tdata, pending_hashes[0]);
                    void'(pending_hashes.pop_front());
                    hashes_checked++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Input side. Tasks enter and leave at a falling edge; tvalid stays up
    // across back-to-back beats and is only dropped while the sender idles.
    // ---------------------------------------------------------------
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        absorb_char(c);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // Random string: mostly 1..31 bytes, some empty, some whole blocks up to
    // the limit, some running past the limit.
    task automatic send_string();
        int pick;
        int len;
        int k;
        pick = $urandom_range(9);
        case (pick)
            0: begin
                len = 0;
            end
            1: begin
                len = $urandom_range(STR_LIMIT + 8, STR_LIMIT + 1);
                long_strings++;
            end
            2: begin
                len = 8 * $urandom_range(4, 1);
            end
            default: begin
                len = $urandom_range(STR_LIMIT - 1, 1);
            end
        endcase
        for (k = 0; k < len; k++)
            send_char(8'($urandom_range(255, 1)));
        send_char(8'h00);
        strings_sent++;
    endtask

    // Stop offering, wait for the last hash, then let the block go quiet.
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (pending_hashes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [shs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            shs_pkg::REG_KEY_LOW:    key_lo  = val;
            shs_pkg::REG_INIT_CONST: key_mix = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Both key registers plus junk into the unused indexes.
    task automatic set_keys(input logic [63:0] klo, input logic [63:0] kmix);
        write_reg(REG_SPARE_A, {$urandom, $urandom});
        write_reg(shs_pkg::REG_KEY_LOW, klo);
        write_reg(REG_SPARE_B, {$urandom, $urandom});
        write_reg(shs_pkg::REG_INIT_CONST, kmix);
        cfg_valid <= 1'b0;
        key_settings++;
    endtask

    task automatic random_phase(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
            send_string();
        drain_and_settle();
    endtask

    // Directed strings, run with the reset keys. No hash here can be read
    // off without running the cipher, so all of them go through the
    // predictor; the cipher itself is pinned by the published vector below.
    logic [7:0] directed_bytes [0:22];

    initial begin
        int i;
        logic [63:0] kat;

        directed_bytes = '{
            8'h00,                                            // empty string
            8'h05, 8'h00,                                     // byte that packs to zero
            8'hFF, 8'h01, 8'h00,                              // byte extremes
            8'h80, 8'h7F, 8'hAA, 8'h55, 8'hFE, 8'h01, 8'hC3, 8'h3C,
            8'h00,                                            // exactly one block
            8'h11, 8'h22, 8'h33, 8'h44, 8'h66, 8'h77, 8'h88,
            8'h00                                             // seven-byte tail
        };

        // Published Speck64/128 known answer, key words remapped onto the
        // two registers: upper half 1b1a1918_13121110.
        kat = speck_enc(64'h7475432d_3b726574, 64'h0b0a0908_03020100,
                        64'h10101010_10101010);
        if (kat !== 64'h454e028b_8c6fa548)
            report_mismatch("cipher known answer", kat, 64'h454e028b_8c6fa548);

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset keys, full rate both sides
        for (i = 0; i < 23; i++)
            send_char(directed_bytes[i]);
        drain_and_settle();

        // all-ones keys, no idling
        set_keys('1, '1);
        random_phase(PHASE_BYTES);

        // known-answer key, sender idle 45%
        set_keys(64'h0b0a0908_03020100, 64'h10101010_10101010);
        send_idle_pct = 45;
        random_phase(PHASE_BYTES);

        // random keys, receiver stalling 45%
        set_keys({$urandom, $urandom}, {$urandom, $urandom});
        send_idle_pct  = 0;
        recv_stall_pct = 45;
        random_phase(PHASE_BYTES);

        // random keys, both sides 38%
        set_keys({$urandom, $urandom}, {$urandom, $urandom});
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        random_phase(PHASE_BYTES);

        // Backpressure: zero low key, all-ones mix. The output is held off
        // for a long stretch while bytes keep coming, so the first hash
        // parks the back end and the job queue fills into s_tready.
        set_keys('0, '1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge aclk);
        hold_left = HOLD_CYCLES;
        @(negedge aclk);
        begin
            int start;
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES / 2)
                send_string();
            // sender waits for every hash before going on
            s_tvalid <= 1'b0;
            while (pending_hashes.size() != 0)
                @(posedge aclk);
            @(negedge aclk);
            while (bytes_sent - start < PHASE_BYTES)
                send_string();
        end
        drain_and_settle();

        $display("run: %0d strings (%0d past the length limit), %0d bytes, %0d key settings",
                 strings_sent, long_strings, bytes_sent, key_settings);
        $display("run: %0d hashes checked, %0d cycles with the input held off",
                 hashes_checked, in_stall_cycles);
        if (err_count == 0 && pending_hashes.size() == 0) begin
            $display("tb_speck_string_hash: clean");
        end else begin
            $display("tb_speck_string_hash: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("timeout with %0d hashes outstanding", pending_hashes.size());
        $display("tb_speck_string_hash: errors");
        $finish;
    end

endmodule

// File: files.f
sv/shs_pkg.sv
sv/shs_front.sv
sv/shs_queue.sv
sv/shs_cipher.sv
sv/shs_back.sv
sv/speck_string_hash.sv
test/tb_speck_string_hash.sv
